>>> sv/timer_priority_queue_top_defines.svh
// Assertion macros shared by the timer queue checker.
`ifndef TIMER_PRIORITY_QUEUE_TOP_DEFINES_SVH
`define TIMER_PRIORITY_QUEUE_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define TPQ_ASSERT_SAME(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("timer queue check failed");
// Assert that a condition implies a consequence in the next cycle.
`define TPQ_ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("timer queue check failed");
`endif

>>> sv/tpq_pkg.sv
// Package with codes and types of the timer priority queue.
package tpq_pkg;
	localparam int unsigned OP_W = 3;
	localparam int unsigned ST_W = 3;
	localparam int unsigned HANDLE_W = 6;
	localparam int unsigned HANDLE_SLOTS = 64;
	localparam int unsigned SEC_W = 32;
	localparam int unsigned USEC_W = 20;
	localparam int unsigned KEY_W = SEC_W + USEC_W;
	localparam int unsigned PAYLOAD_W = 32;

	localparam logic [OP_W-1:0] OP_ADD = 3'd0;
	localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
	localparam logic [OP_W-1:0] OP_RESCHED = 3'd2;
	localparam logic [OP_W-1:0] OP_PEEK = 3'd3;
	localparam logic [OP_W-1:0] OP_POP = 3'd4;

	localparam logic [ST_W-1:0] ST_OK = 3'd0;
	localparam logic [ST_W-1:0] ST_FULL = 3'd1;
	localparam logic [ST_W-1:0] ST_EMPTY = 3'd2;
	localparam logic [ST_W-1:0] ST_NOT_DUE = 3'd3;
	localparam logic [ST_W-1:0] ST_BAD_HANDLE = 3'd4;

	// Candidate passed along the cell chain during the scan.
	typedef struct packed {
		logic                 valid;
		logic [KEY_W-1:0]     key;
		logic [HANDLE_W-1:0]  handle;
		logic [PAYLOAD_W-1:0] payload;
	} tpq_cand_t;

	// Command broadcast to every cell.
	typedef struct packed {
		logic                 write;
		logic                 clear;
		logic [HANDLE_W-1:0]  handle;
		logic                 set_key;
		logic                 set_payload;
		logic [KEY_W-1:0]     key;
		logic [PAYLOAD_W-1:0] payload;
	} tpq_cmd_t;
endpackage

>>> sv/timer_priority_queue_top.sv
// Top level of the timer priority queue: controller around the cell row.
// Usage:
//  Input channel (valid/ready) carries one operation: add, delete, reschedule,
//  peek, or pop if due. Output channel (valid/ready) returns one result item
//  per operation: status, handle, payload and the earliest deadline afterward.
//  Sequence: an item waits for a minimum scan through the cell row, which moves
//  eight cells per cycle. The operation is then applied, and in the cycle after
//  that a second scan starts and produces the new minimum; the result is shown
//  once that scan is done, and the next item is taken only after it has left.
//  Add takes the lowest free slot, found combinationally from the used bits.
//  Ties between equal deadlines go to the lowest handle.
//  Only handles below min(DEPTH,64) are valid.
//  Reset empties the queue at once; no clearing pass is needed.
//  A stalled receiver holds the result in the output register; no new item is
//  taken until it leaves.
module timer_priority_queue_top #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [tpq_pkg::OP_W-1:0]        operation,
	input  logic [tpq_pkg::SEC_W-1:0]       time_sec,
	input  logic [tpq_pkg::USEC_W-1:0]      time_usec,
	input  logic [tpq_pkg::HANDLE_W-1:0]    entry_handle,
	input  logic [tpq_pkg::PAYLOAD_W-1:0]   payload_in,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [tpq_pkg::ST_W-1:0]        status,
	output logic [tpq_pkg::HANDLE_W-1:0]    handle_out,
	output logic [tpq_pkg::PAYLOAD_W-1:0]   payload_out,
	output logic                            min_valid,
	output logic [tpq_pkg::SEC_W-1:0]       min_sec,
	output logic [tpq_pkg::USEC_W-1:0]      min_usec
);
	localparam int unsigned SLOTS = (DEPTH < tpq_pkg::HANDLE_SLOTS) ?
		DEPTH : tpq_pkg::HANDLE_SLOTS;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN1 = 5'b00010,
		S_APPLY = 5'b00100,
		S_SCAN2 = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t                         state_q;
	logic [tpq_pkg::OP_W-1:0]       op_q;
	logic [tpq_pkg::KEY_W-1:0]      key_q;
	logic [tpq_pkg::HANDLE_W-1:0]   hnd_q;
	logic [tpq_pkg::PAYLOAD_W-1:0]  pay_q;
	logic                           first_q;
	logic [tpq_pkg::ST_W-1:0]       st_q;
	logic [tpq_pkg::HANDLE_W-1:0]   hout_q;
	logic [tpq_pkg::PAYLOAD_W-1:0]  pout_q;
	logic                           mv_q;
	logic [tpq_pkg::KEY_W-1:0]      mkey_q;

	tpq_pkg::tpq_cmd_t  cmd;
	tpq_pkg::tpq_cand_t best;
	logic               scan_start, scan_done;
	logic [SLOTS-1:0]   used;
	logic               free_found;
	logic [tpq_pkg::HANDLE_W-1:0] free_idx;
	logic               h_ok;

	tpq_chain #(.SLOTS(SLOTS), .GROUP(8)) u_chain (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .scan_start(scan_start),
		.best(best), .scan_done(scan_done), .used(used)
	);

	// Find the lowest free slot.
	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (!used[i]) begin
				free_found = 1'b1;
				free_idx = i[tpq_pkg::HANDLE_W-1:0];
			end
		end
	end

	assign h_ok = ({1'b0, hnd_q} < 7'(SLOTS)) && used[hnd_q[$clog2(SLOTS)-1:0]];

	// Start the rescan once the applied write is visible in the cells.
	assign in_ready = (state_q == S_IDLE);
	assign scan_start = (state_q == S_IDLE && in_valid) || first_q;

	// Build the write command for the chosen operation.
	always_comb begin
		cmd = '0;
		cmd.key = key_q;
		cmd.payload = pay_q;
		if (state_q == S_APPLY) begin
			case (op_q)
				tpq_pkg::OP_ADD: begin
					cmd.write = free_found;
					cmd.handle = free_idx;
					cmd.set_key = 1'b1;
					cmd.set_payload = 1'b1;
				end
				tpq_pkg::OP_DELETE: begin
					cmd.write = h_ok;
					cmd.clear = 1'b1;
					cmd.handle = hnd_q;
				end
				tpq_pkg::OP_RESCHED: begin
					cmd.write = h_ok;
					cmd.handle = hnd_q;
					cmd.set_key = 1'b1;
				end
				tpq_pkg::OP_POP: begin
					cmd.write = best.valid && (best.key <= key_q);
					cmd.clear = 1'b1;
					cmd.handle = best.handle;
				end
				default: begin
					cmd.write = 1'b0;
				end
			endcase
		end
	end

	// Sequence: scan, apply, rescan, present.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			first_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: if (in_valid) begin
					state_q <= S_SCAN1;
				end
				S_SCAN1: if (scan_done) begin
					state_q <= S_APPLY;
				end
				S_APPLY: state_q <= S_SCAN2;
				S_SCAN2: if (scan_done) begin
					state_q <= S_OUT;
				end
				S_OUT: if (out_ready) begin
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			first_q <= (state_q == S_APPLY);
		end
	end

	// Capture the item and produce the result fields.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			op_q <= operation;
			key_q <= {time_sec, time_usec};
			hnd_q <= entry_handle;
			pay_q <= payload_in;
		end
		if (state_q == S_APPLY) begin
			st_q <= tpq_pkg::ST_OK;
			hout_q <= '0;
			pout_q <= '0;
			case (op_q)
				tpq_pkg::OP_ADD: begin
					if (free_found) begin
						hout_q <= free_idx;
					end else begin
						st_q <= tpq_pkg::ST_FULL;
					end
				end
				tpq_pkg::OP_DELETE, tpq_pkg::OP_RESCHED: begin
					if (!h_ok) begin
						st_q <= tpq_pkg::ST_BAD_HANDLE;
					end
				end
				tpq_pkg::OP_POP: begin
					if (!best.valid) begin
						st_q <= tpq_pkg::ST_EMPTY;
					end else if (best.key > key_q) begin
						st_q <= tpq_pkg::ST_NOT_DUE;
					end else begin
						hout_q <= best.handle;
						pout_q <= best.payload;
					end
				end
				default: begin
					if (!best.valid) begin
						st_q <= tpq_pkg::ST_EMPTY;
					end
				end
			endcase
		end
		if (state_q == S_SCAN2 && scan_done) begin
			mv_q <= best.valid;
			mkey_q <= best.valid ? best.key : '0;
		end
	end

	assign out_valid = (state_q == S_OUT);
	assign status = st_q;
	assign handle_out = hout_q;
	assign payload_out = pout_q;
	assign min_valid = mv_q;
	assign min_sec = mkey_q[tpq_pkg::KEY_W-1:tpq_pkg::USEC_W];
	assign min_usec = mkey_q[tpq_pkg::USEC_W-1:0];
endmodule

>>> sv/tpq_cell.sv
// One slot of the timer queue: holds a timer and folds it into the running minimum.
module tpq_cell #(
	parameter logic [tpq_pkg::HANDLE_W-1:0] IDX = '0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tpq_pkg::tpq_cmd_t  cmd,
	input  tpq_pkg::tpq_cand_t cand_in,
	output tpq_pkg::tpq_cand_t cand_out,
	output logic               used
);
	logic                          used_q;
	logic [tpq_pkg::KEY_W-1:0]     key_q;
	logic [tpq_pkg::PAYLOAD_W-1:0] payload_q;
	logic                          hit;

	assign hit = cmd.write && (cmd.handle == IDX);
	assign used = used_q;

	// Update the slot on a command addressed to it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= 1'b0;
		end else if (hit) begin
			used_q <= !cmd.clear;
		end
	end

	always_ff @(posedge clk) begin
		if (hit && cmd.set_key) begin
			key_q <= cmd.key;
		end
		if (hit && cmd.set_payload) begin
			payload_q <= cmd.payload;
		end
	end

	// Keep the incoming candidate unless this slot is strictly earlier.
	always_comb begin
		cand_out = cand_in;
		if (used_q && (!cand_in.valid || key_q < cand_in.key)) begin
			cand_out.valid = 1'b1;
			cand_out.key = key_q;
			cand_out.handle = IDX;
			cand_out.payload = payload_q;
		end
	end
endmodule

>>> sv/tpq_chain.sv
// Row of timer cells; the minimum ripples down the row in groups, one group per cycle.
module tpq_chain #(
	parameter int unsigned SLOTS = 64,
	parameter int unsigned GROUP = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tpq_pkg::tpq_cmd_t  cmd,
	input  logic               scan_start,
	output tpq_pkg::tpq_cand_t best,
	output logic               scan_done,
	output logic [SLOTS-1:0]   used
);
	localparam int unsigned NGRP = (SLOTS + GROUP - 1) / GROUP;

	tpq_pkg::tpq_cand_t link [SLOTS+1];
	tpq_pkg::tpq_cand_t stage_q [NGRP];
	logic [NGRP-1:0]    run_q;

	// Each group starts from the previous group's registered result.
	genvar g, k;
	generate
		for (g = 0; g < NGRP; g++) begin : g_grp
			for (k = 0; k < GROUP; k++) begin : g_cell
				if (g * GROUP + k < SLOTS) begin : g_live
					localparam int unsigned I = g * GROUP + k;
					tpq_pkg::tpq_cand_t cin;
					if (k == 0) begin : g_head
						if (g == 0) begin : g_first
							assign cin = link[0];
						end else begin : g_rest
							assign cin = stage_q[g-1];
						end
					end else begin : g_body
						assign cin = link[I];
					end
					tpq_cell #(.IDX(I[tpq_pkg::HANDLE_W-1:0])) u_cell (
						.clk(clk), .arst_n(arst_n), .cmd(cmd),
						.cand_in(cin), .cand_out(link[I+1]), .used(used[I])
					);
				end
			end
			localparam int unsigned LAST = ((g + 1) * GROUP < SLOTS) ?
				(g + 1) * GROUP : SLOTS;
			always_ff @(posedge clk) begin
				stage_q[g] <= link[LAST];
			end
		end
	endgenerate
	assign link[0] = '0;

	// Track how far the scan has advanced.
	generate
		if (NGRP > 1) begin : g_run_multi
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q <= '0;
				end else begin
					run_q <= {run_q[NGRP-2:0], scan_start};
				end
			end
		end else begin : g_run_one
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					run_q <= '0;
				end else begin
					run_q <= scan_start;
				end
			end
		end
	endgenerate

	assign best = stage_q[NGRP-1];
	assign scan_done = run_q[NGRP-1];
endmodule

>>> sv/tpq_checker.sv
// Port-level checker for the timer priority queue, bound to the top level.
`include "timer_priority_queue_top_defines.svh"
module tpq_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [tpq_pkg::ST_W-1:0]      status,
	input logic                          min_valid,
	input logic [tpq_pkg::SEC_W-1:0]     min_sec,
	input logic [tpq_pkg::USEC_W-1:0]    min_usec
);
	// One item in flight: no intake while a result is shown.
	`TPQ_ASSERT_SAME(a_no_overlap, clk, arst_n, out_valid, !in_ready)
	// A result follows its item, never in the next cycle.
	`TPQ_ASSERT_NEXT(a_no_instant, clk, arst_n, in_valid && in_ready, !out_valid)
	// An empty report carries a zero deadline.
	`TPQ_ASSERT_SAME(a_empty_zero, clk, arst_n, out_valid && !min_valid,
		min_sec == '0 && min_usec == '0)
	// Stalled result holds.
	`TPQ_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(status))
endmodule

bind timer_priority_queue_top tpq_checker u_tpq_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .status(status),
	.min_valid(min_valid), .min_sec(min_sec), .min_usec(min_usec)
);
